FILE: rtl/core/nfs_pkg.sv
// Shared types and constants for the nearest feature search block.
// No dependencies; imported by nfs_dist_unit and nearest_feature_search_top.
`timescale 1ns / 1ps
`default_nettype none

package nfs_pkg;

    // Default table depth
    localparam int MAX_FEATURES_DEF = 256;

    // Field widths
    localparam int COORD_W = 16;
    localparam int INTEN_W = 16;
    localparam int IDX_W   = 8;
    localparam int DIST_W  = 33;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 32;
    localparam int OP_W    = 2;

    // Stream widths
    localparam int IN_W  = 3 * COORD_W;
    localparam int OUT_W = 104;

    // Operation codes, carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [DIST_W-1:0]  second_dist_sq;
        logic [IDX_W-1:0]   second_index;
        logic               second_found;
        logic [INTEN_W-1:0] closest_intensity;
        logic [DIST_W-1:0]  closest_dist_sq;
        logic [IDX_W-1:0]   closest_index;
        logic               closest_found;
        logic               table_full;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // Status of the distance pipeline
    typedef struct packed {
        logic out_valid;
        logic busy;
    } dist_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/nfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nfs_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/nfs_dist_unit.sv
// Three-stage squared-distance pipeline: difference, square, sum.
// Depends on nfs_pkg. Carries entry index and intensity alongside.
`timescale 1ns / 1ps
`default_nettype none

module nfs_dist_unit
    import nfs_pkg::*;
#(
    parameter int AW = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic [COORD_W-1:0] in_x,
    input  wire logic [COORD_W-1:0] in_y,
    input  wire logic [INTEN_W-1:0] in_inten,
    input  wire logic [AW-1:0]      in_idx,
    input  wire logic [COORD_W-1:0] q_x,
    input  wire logic [COORD_W-1:0] q_y,
    output dist_stat_t              stat,
    output logic [DIST_W-1:0]       out_dist,
    output logic [AW-1:0]           out_idx,
    output logic [INTEN_W-1:0]      out_inten
);

    logic                      s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [DIST_W-1:0]         dist_reg;
    logic [AW-1:0]             idx1_reg, idx2_reg, idx3_reg;
    logic [INTEN_W-1:0]        int1_reg, int2_reg, int3_reg;

    // Sign-extended coordinate differences
    assign dx_next = $signed({in_x[COORD_W-1], in_x}) - $signed({q_x[COORD_W-1], q_x});
    assign dy_next = $signed({in_y[COORD_W-1], in_y}) - $signed({q_y[COORD_W-1], q_y});

    // Squares fit in 32 bits: |d| <= 65535
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        idx1_reg <= in_idx;
        int1_reg <= in_inten;
        sqx_reg  <= sqx_full[SQ_W-1:0];
        sqy_reg  <= sqy_full[SQ_W-1:0];
        idx2_reg <= idx1_reg;
        int2_reg <= int1_reg;
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        idx3_reg <= idx2_reg;
        int3_reg <= int2_reg;
    end

    assign stat.out_valid = s3_v_reg;
    assign stat.busy      = s1_v_reg | s2_v_reg | s3_v_reg;
    assign out_dist       = dist_reg;
    assign out_idx        = idx3_reg;
    assign out_inten      = int3_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_feature_search_top.sv
// Insert, clear and unused opcodes pass from idle straight to the done state, which loads m_tdata.
// A query over N > 0 stored features first reads the N table entries through the single
// distance pipeline, then waits in the drain state until the pipeline is empty, then loads.
// Throughput: one item at a time, s_tready is high only while the sequencer is idle;
// the done state holds while the previous result still waits for m_tready, then returns to idle.
// Reset (aresetn, synchronous, active low) empties the table and drops any pending word.
// Top level of the nearest feature search. Depends on nfs_pkg, nfs_ram, nfs_dist_unit.
`timescale 1ns / 1ps
`default_nettype none

module nearest_feature_search_top
    import nfs_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // [15:0] point_x, [31:16] point_y, [47:32] feature_intensity
    input  wire logic [IN_W-1:0]  s_tdata,
    // [1:0] opcode
    input  wire logic [OP_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [0] table_full, [1] closest_found, [9:2] closest_index,
    // [42:10] closest_dist_sq, [58:43] closest_intensity, [59] second_found,
    // [67:60] second_index, [100:68] second_dist_sq, [103:101] zero
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW = $clog2(MAX_FEATURES);
    localparam int CW = $clog2(MAX_FEATURES + 1);
    localparam int RW = COORD_W * 2 + INTEN_W;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_cnt_reg, rd_cnt_next;
    op_t                op_reg;
    logic               full_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg;
    logic               v0_reg;
    logic [AW-1:0]      idx0_reg;
    logic               issue, ram_we, load_out, accept;
    op_t                in_op;
    logic [RW-1:0]      ram_rdata;

    // Best and runner-up tracker
    logic               have1_reg, have2_reg;
    logic [DIST_W-1:0]  d1_reg, d2_reg;
    logic [AW-1:0]      i1_reg, i2_reg;
    logic [INTEN_W-1:0] int1_reg;

    dist_stat_t         dstat;
    logic [DIST_W-1:0]  du_dist;
    logic [AW-1:0]      du_idx;
    logic [INTEN_W-1:0] du_inten;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg;
    res_t               res;

    assign in_op  = op_t'(s_tuser);
    assign accept = s_tvalid & s_tready;

    // Feature table: {intensity, y, x}
    nfs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_FEATURES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[RW-1:0]),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    nfs_dist_unit #(
        .AW (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_x      (ram_rdata[COORD_W-1:0]),
        .in_y      (ram_rdata[2*COORD_W-1:COORD_W]),
        .in_inten  (ram_rdata[RW-1:2*COORD_W]),
        .in_idx    (idx0_reg),
        .q_x       (qx_reg),
        .q_y       (qy_reg),
        .stat      (dstat),
        .out_dist  (du_dist),
        .out_idx   (du_idx),
        .out_inten (du_inten)
    );

    // Sequencer: next state and controls
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        issue       = 1'b0;
        ram_we      = 1'b0;
        load_out    = 1'b0;
        s_tready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DONE;
                    case (in_op)
                        OP_INSERT: begin
                            if (count_reg < CW'(MAX_FEATURES)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            rd_cnt_next = '0;
                            if (count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                issue       = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v0_reg && !dstat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            v0_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            v0_reg     <= issue;
        end
    end

    // Item capture and read index alignment
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_op;
            full_reg <= (in_op == OP_INSERT) && (count_reg == CW'(MAX_FEATURES));
            qx_reg   <= s_tdata[COORD_W-1:0];
            qy_reg   <= s_tdata[2*COORD_W-1:COORD_W];
        end
        idx0_reg <= rd_cnt_reg[AW-1:0];
    end

    // Keep nearest and runner-up; strict compares keep the lowest index on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end else if (accept) begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end else if (dstat.out_valid) begin
            if (!have1_reg || du_dist < d1_reg) begin
                have1_reg <= 1'b1;
                have2_reg <= have1_reg;
            end else if (!have2_reg || du_dist < d2_reg) begin
                have2_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dstat.out_valid) begin
            if (!have1_reg || du_dist < d1_reg) begin
                d1_reg   <= du_dist;
                i1_reg   <= du_idx;
                int1_reg <= du_inten;
                d2_reg   <= d1_reg;
                i2_reg   <= i1_reg;
            end else if (!have2_reg || du_dist < d2_reg) begin
                d2_reg <= du_dist;
                i2_reg <= du_idx;
            end
        end
    end

    // Result word
    always_comb begin
        res            = '0;
        res.table_full = full_reg;
        if (op_reg == OP_QUERY) begin
            res.table_full = 1'b0;
            if (have1_reg) begin
                res.closest_found     = 1'b1;
                res.closest_index     = IDX_W'(i1_reg);
                res.closest_dist_sq   = d1_reg;
                res.closest_intensity = int1_reg;
            end
            if (have2_reg) begin
                res.second_found   = 1'b1;
                res.second_index   = IDX_W'(i2_reg);
                res.second_dist_sq = d2_reg;
            end
        end
    end

    // Output register
    assign m_tvalid_next = load_out | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {{(OUT_W - RES_W){1'b0}}, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_FEATURES))
        else $error("feature count beyond table depth");

    // Scan reads only written entries
    a_scan_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rd_cnt_reg < count_reg)
        else $error("scan address beyond feature count");

    // Runner-up never closer than the nearest
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        have2_reg |-> (have1_reg && d1_reg <= d2_reg))
        else $error("runner-up closer than nearest");

    // A word with a second hit also has a first one, and no full flag
    a_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[59] |-> (m_tdata[1] && !m_tdata[0]))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for nearest_feature_search_top: directed table, then random traffic.
// Expected words come from a behavioral table-and-scan predictor; depends on nfs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import nfs_pkg::*;

    localparam int  MAX_FEAT        = MAX_FEATURES_DEF;
    localparam int  RANDOM_ITEMS    = 480;
    localparam int  PHASE_LEN       = 160;
    localparam int  FILL_AT         = 240;
    localparam int  SMALL_TABLE     = 24;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  DRAIN_CYCLES    = 300;
    localparam int  WATCHDOG_LIMIT  = 4000;
    localparam int  MAX_REPORTS     = 10;
    // Opcode outside the defined set; must be a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // 2 * 65535^2: opposite corners of the coordinate range
    localparam logic [DIST_W-1:0] CORNER_DIST = 33'd8589672450;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INTEN_W-1:0] inten;
        logic               fixed;
        res_t               want;
    } dir_row_t;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]  s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Predictor state: feature table and fill level
    logic signed [COORD_W-1:0] feat_x [MAX_FEAT];
    logic signed [COORD_W-1:0] feat_y [MAX_FEAT];
    logic [INTEN_W-1:0]        feat_inten [MAX_FEAT];
    int                        stored_count = 0;

    res_t     expected_words [$];
    dir_row_t directed_rows [$];
    int       mismatch_count   = 0;
    int       stall_cycles     = 0;
    int       tx_idle_pct      = 0;
    int       rx_idle_pct      = 0;
    bit       hold_off_pending = 1'b0;

    nearest_feature_search_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Squared distance from stored feature i to the query point
    function automatic longint sq_dist(input int i, input logic signed [COORD_W-1:0] qx,
                                       input logic signed [COORD_W-1:0] qy);
        longint dx;
        longint dy;
        dx = feat_x[i];
        dy = feat_y[i];
        dx = dx - qx;
        dy = dy - qy;
        return dx * dx + dy * dy;
    endfunction

    // Applies one word to the predicted table and returns the expected result
    function automatic res_t predict_word(input logic [OP_W-1:0] op,
                                          input logic signed [COORD_W-1:0] qx,
                                          input logic signed [COORD_W-1:0] qy,
                                          input logic [INTEN_W-1:0] inten);
        res_t   w;
        longint d;
        longint best_d;
        longint second_d;
        int     best_i;
        int     second_i;
        bit     have_best;
        bit     have_second;
        w = '0;
        best_d = 0;
        second_d = 0;
        best_i = 0;
        second_i = 0;
        have_best = 1'b0;
        have_second = 1'b0;
        case (op)
            OP_INSERT: begin
                if (stored_count >= MAX_FEAT) begin
                    w.table_full = 1'b1;
                end else begin
                    feat_x[stored_count]     = qx;
                    feat_y[stored_count]     = qy;
                    feat_inten[stored_count] = inten;
                    stored_count++;
                end
            end
            OP_CLEAR: begin
                stored_count = 0;
            end
            OP_QUERY: begin
                // nearest, lowest index wins a tie
                for (int i = 0; i < stored_count; i++) begin
                    d = sq_dist(i, qx, qy);
                    if (!have_best || d < best_d) begin
                        best_d = d;
                        best_i = i;
                        have_best = 1'b1;
                    end
                end
                // nearest among the rest
                for (int i = 0; i < stored_count; i++) begin
                    if (i != best_i) begin
                        d = sq_dist(i, qx, qy);
                        if (!have_second || d < second_d) begin
                            second_d = d;
                            second_i = i;
                            have_second = 1'b1;
                        end
                    end
                end
                if (have_best) begin
                    w.closest_found     = 1'b1;
                    w.closest_index     = best_i[IDX_W-1:0];
                    w.closest_dist_sq   = best_d[DIST_W-1:0];
                    w.closest_intensity = feat_inten[best_i];
                end
                if (have_second) begin
                    w.second_found   = 1'b1;
                    w.second_index   = second_i[IDX_W-1:0];
                    w.second_dist_sq = second_d[DIST_W-1:0];
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic res_t make_word(input logic full, input logic cf,
                                       input logic [IDX_W-1:0] ci,
                                       input logic [DIST_W-1:0] cd,
                                       input logic [INTEN_W-1:0] cint, input logic sf,
                                       input logic [IDX_W-1:0] si,
                                       input logic [DIST_W-1:0] sd);
        res_t w;
        w.table_full        = full;
        w.closest_found     = cf;
        w.closest_index     = ci;
        w.closest_dist_sq   = cd;
        w.closest_intensity = cint;
        w.second_found      = sf;
        w.second_index      = si;
        w.second_dist_sq    = sd;
        return w;
    endfunction

    // Coordinate mix: tight cluster for ties, full range, range extremes
    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 16'($urandom_range(16)) - 16'd8;
        else if (r < 85)
            return 16'($urandom);
        else
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [INTEN_W-1:0] inten,
                           input logic fixed, input res_t want);
        dir_row_t row;
        row.op    = op;
        row.x     = x;
        row.y     = y;
        row.inten = inten;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Offers one word, waits for acceptance, then records its expected result
    task automatic send_word(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [INTEN_W-1:0] inten,
                             input logic fixed, input res_t want);
        res_t w;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {inten, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        w = predict_word(op, x, y, inten);
        expected_words.push_back(fixed ? want : w);
    endtask

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  exp full=%0d cf=%0d ci=%0d cd=%0d cint=%0d sf=%0d si=%0d sd=%0d",
                     want.table_full, want.closest_found, want.closest_index,
                     want.closest_dist_sq, want.closest_intensity, want.second_found,
                     want.second_index, want.second_dist_sq);
            $display("  got full=%0d cf=%0d ci=%0d cd=%0d cint=%0d sf=%0d si=%0d sd=%0d",
                     got.table_full, got.closest_found, got.closest_index,
                     got.closest_dist_sq, got.closest_intensity, got.second_found,
                     got.second_index, got.second_dist_sq);
        end
    endtask

    // Result side: random backpressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_pending = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin : check_word
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.table_full !== want.table_full
                        || got.closest_found !== want.closest_found
                        || got.closest_index !== want.closest_index
                        || got.closest_dist_sq !== want.closest_dist_sq
                        || got.closest_intensity !== want.closest_intensity
                        || got.second_found !== want.second_found
                        || got.second_index !== want.second_index
                        || got.second_dist_sq !== want.second_dist_sq)
                    report_mismatch("result word mismatch", want, got);
            end
        end
    end

    // Watchdog: cycles with no word accepted on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, unused opcode, corners, ties, clear behavior
        add_row(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b1, '0);
        add_row(OP_UNUSED, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, '0);
        add_row(OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b1, '0);
        add_row(OP_INSERT, 16'h8000, 16'h8000, 16'hFFFF, 1'b1, '0);
        add_row(OP_QUERY,  16'h7FFF, 16'h7FFF, 16'h0000, 1'b1,
                make_word(1'b0, 1'b1, 8'd0, CORNER_DIST, 16'hFFFF, 1'b0, 8'd0, '0));
        add_row(OP_INSERT, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, '0);
        add_row(OP_QUERY,  16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1,
                make_word(1'b0, 1'b1, 8'd1, '0, 16'h0000, 1'b1, 8'd0, CORNER_DIST));
        add_row(OP_INSERT, 16'h0000, 16'h0000, 16'hA5A5, 1'b0, '0);
        add_row(OP_INSERT, 16'h0000, 16'h0000, 16'h5A5A, 1'b0, '0);
        add_row(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(OP_QUERY,  16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0);
        add_row(OP_QUERY,  16'h0001, 16'hFFFF, 16'h0000, 1'b0, '0);
        add_row(OP_INSERT, 16'hFFFF, 16'h0001, 16'h8000, 1'b0, '0);
        add_row(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0);
        // stale entries must not show up after a clear
        add_row(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b1, '0);
        add_row(OP_INSERT, 16'h1234, 16'hEDCB, 16'h0F0F, 1'b0, '0);
        add_row(OP_QUERY,  16'h1230, 16'hEDC0, 16'h0000, 1'b0, '0);
        add_row(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0);
        add_row(OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b1, '0);

        tx_idle_pct = 38;
        rx_idle_pct = 52;
        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].inten, directed_rows[i].fixed, directed_rows[i].want);

        // Random: mostly inserts and queries on small tables, some clears and noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin : random_item
            logic [OP_W-1:0]    op;
            logic [COORD_W-1:0] x;
            logic [COORD_W-1:0] y;
            int                 r;
            int                 k;
            if (n == PHASE_LEN) begin
                tx_idle_pct = 52;
                rx_idle_pct = 38;
            end else if (n == 2 * PHASE_LEN) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_off_pending = 1'b1;
            end

            // One pass filling the table past capacity, then full-table queries
            if (n == FILL_AT) begin
                send_word(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
                repeat (MAX_FEAT + 4)
                    send_word(OP_INSERT, pick_coord(), pick_coord(), 16'($urandom), 1'b0, '0);
                repeat (3)
                    send_word(OP_QUERY, pick_coord(), pick_coord(), 16'($urandom), 1'b0, '0);
                k = $urandom_range(MAX_FEAT - 1);
                send_word(OP_QUERY, feat_x[k], feat_y[k], 16'($urandom), 1'b0, '0);
                send_word(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
            end

            r = $urandom_range(99);
            if (r < 6)
                op = OP_UNUSED;
            else if (r < 12)
                op = OP_CLEAR;
            else if (r < 56 && stored_count < SMALL_TABLE)
                op = OP_INSERT;
            else
                op = OP_QUERY;
            x = pick_coord();
            y = pick_coord();
            // reuse a stored point now and then: zero distances and duplicates
            if (stored_count > 0 && $urandom_range(5) == 0) begin
                k = $urandom_range(stored_count - 1);
                x = feat_x[k];
                y = feat_y[k];
            end
            send_word(op, x, y, 16'($urandom), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow time for any stray word
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
